[hdl/ame_pkg.sv]
// ----------------------------------------------------------------------------
// ame_pkg
// Shared sizes, command codes and control types of the attention matmul engine.
// ----------------------------------------------------------------------------
package ame_pkg;

  localparam int MAX_LEN    = 64;
  localparam int MAX_DIM    = 64;
  localparam int STORE_COLS = (MAX_LEN > MAX_DIM) ? MAX_LEN : MAX_DIM;

  localparam int ROW_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COL_W  = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int SIZE_W = 7;
  localparam int ELEM_W = 16;
  localparam int MUL_W  = 2 * ELEM_W;
  localparam int PROD_W = 38;
  localparam int ACC_RAW_W = MUL_W + COL_W + 1;
  localparam int ACC_W  = (ACC_RAW_W > PROD_W) ? ACC_RAW_W : PROD_W;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SEQ_LEN  = 2'd1;
  localparam logic [1:0] REG_HEAD_DIM = 2'd2;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

[hdl/attention_matmul_engine_unit.sv]
// ----------------------------------------------------------------------------
// attention_matmul_engine_unit
// Operand stores plus a sequencer that runs one dot product per read item.
// ----------------------------------------------------------------------------
// Load items write the element at the accept edge and leave busy low. A read
// item inside the result bounds holds busy high while it sums inner products
// (inner = head_dim in mode 0, seq_len in mode 1), one multiply-accumulate per
// cycle on the single shared unit fed by the two store read ports through
// the registered read, multiply and accumulate stages; out_valid then shows
// the result for exactly one cycle, rising as busy drops. A read outside
// the bounds answers on the next cycle with out_out_of_range set and a zero
// product; a read inside the bounds with an inner length of zero also
// answers on the next cycle, with a zero product and no flag. Results cannot
// be stalled: capture them on the strobe. Operand entries are not cleared by
// reset; read only what has been loaded.
module attention_matmul_engine_unit
  import ame_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_command,
  input  logic [5:0]               in_row,
  input  logic [5:0]               in_col,
  input  logic signed [15:0]       in_value,
  output logic                     out_valid,
  output logic signed [PROD_W-1:0] out_product,
  output logic                     out_out_of_range,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              mode_r;
  logic [SIZE_W-1:0] seq_len_r, head_dim_r;
  logic [SIZE_W-1:0] eff_len, eff_dim, cols_a, res_cols, inner;
  logic [SIZE_W-1:0] k_r, k_nxt, last_r, last_nxt;
  logic [5:0]        r_r, c_r, r_nxt, c_nxt;
  logic              v1_r;
  logic              issue;
  logic              accept, row_ok;

  logic signed [ELEM_W-1:0] mem_a [MEM_DEPTH];
  logic signed [ELEM_W-1:0] mem_b [MEM_DEPTH];
  logic signed [ELEM_W-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic                     we_a, we_b;

  mac_ctl_t                 mac_ctl;
  logic                     mac_busy;
  logic signed [PROD_W-1:0] mac_sum;

  logic                     out_valid_r, out_valid_nxt;
  logic                     oor_r, oor_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // sizes clip to the store dimensions
  assign eff_len  = (32'(seq_len_r) > MAX_LEN) ? SIZE_W'(MAX_LEN) : seq_len_r;
  assign eff_dim  = (32'(head_dim_r) > MAX_DIM) ? SIZE_W'(MAX_DIM) : head_dim_r;
  assign cols_a   = mode_r ? eff_len : eff_dim;
  assign res_cols = mode_r ? eff_dim : eff_len;
  assign inner    = mode_r ? eff_len : eff_dim;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign row_ok = SIZE_W'(in_row) < eff_len;

  assign we_a    = accept && (in_command == CMD_LOAD_A) && row_ok &&
                   (SIZE_W'(in_col) < cols_a);
  assign we_b    = accept && (in_command == CMD_LOAD_B) && row_ok &&
                   (SIZE_W'(in_col) < eff_dim);
  assign wr_addr = {ROW_W'(in_row), COL_W'(in_col)};

  assign rd_addr_a = {ROW_W'(r_r), COL_W'(k_r)};
  assign rd_addr_b = mode_r ? {ROW_W'(k_r), COL_W'(c_r)}
                            : {ROW_W'(c_r), COL_W'(k_r)};

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= in_value;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= in_value;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  assign issue         = (state_r == ST_RUN);
  assign mac_ctl.clear = accept;
  assign mac_ctl.valid = v1_r;

  ame_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .a         (rd_a_r),
    .b         (rd_b_r),
    .pipe_busy (mac_busy),
    .sum       (mac_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    out_valid_nxt = 1'b0;
    oor_nxt       = oor_r;
    prod_nxt      = prod_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_READ)) begin
          if (row_ok && (SIZE_W'(in_col) < res_cols)) begin
            if (inner == '0) begin
              // empty dot product
              out_valid_nxt = 1'b1;
              oor_nxt       = 1'b0;
              prod_nxt      = '0;
            end else begin
              state_nxt = ST_RUN;
              k_nxt     = '0;
              last_nxt  = inner - SIZE_W'(1);
              r_nxt     = in_row;
              c_nxt     = in_col;
            end
          end else begin
            out_valid_nxt = 1'b1;
            oor_nxt       = 1'b1;
            prod_nxt      = '0;
          end
        end
      end
      ST_RUN: begin
        k_nxt = k_r + SIZE_W'(1);
        if (k_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last product has landed in the accumulator
        if (!v1_r && !mac_busy) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          oor_nxt       = 1'b0;
          prod_nxt      = mac_sum;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      seq_len_r   <= SIZE_W'(64);
      head_dim_r  <= SIZE_W'(64);
    end else begin
      state_r     <= state_nxt;
      v1_r        <= issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:     mode_r     <= cfg_data[0];
          REG_SEQ_LEN:  seq_len_r  <= cfg_data;
          REG_HEAD_DIM: head_dim_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    last_r <= last_nxt;
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    oor_r  <= oor_nxt;
    prod_r <= prod_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_out_of_range = oor_r;
  assign out_product      = prod_r;

endmodule

[hdl/ame_mac.sv]
// ----------------------------------------------------------------------------
// ame_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a wide
// accumulator with saturation to the 38-bit result range.
// ----------------------------------------------------------------------------
module ame_mac
  import ame_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] a,
  input  logic signed [ELEM_W-1:0] b,
  output logic                     pipe_busy,
  output logic signed [PROD_W-1:0] sum
);

  localparam logic signed [ACC_W-1:0] ACC_PMAX =
    {{(ACC_W - PROD_W + 1){1'b0}}, {(PROD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_PMIN = ~ACC_PMAX;

  logic signed [MUL_W-1:0] prod_r;
  logic                    pv_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    priority if (ctl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_comb begin
    priority if (acc_r > ACC_PMAX) begin
      sum = ACC_PMAX[PROD_W-1:0];
    end else if (acc_r < ACC_PMIN) begin
      sum = ACC_PMIN[PROD_W-1:0];
    end else begin
      sum = acc_r[PROD_W-1:0];
    end
  end

  assign pipe_busy = pv_r;

endmodule

[hdl/ame_checker.sv]
// ----------------------------------------------------------------------------
// ame_checker
// Port-level checks of the attention matmul engine, bound to the top level.
// ----------------------------------------------------------------------------
module ame_checker
  import ame_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_command,
  input logic                     out_valid,
  input logic signed [PROD_W-1:0] out_product,
  input logic                     out_out_of_range
);

  // a flagged result carries no product
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_product == '0)
    else $error("out of range result with nonzero product");

  // a read either starts a dot product or answers at once
  a_read_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_READ |=> busy || out_valid)
    else $error("read item neither started nor answered");

  // loads and the unused command give no result and keep the unit free
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command != CMD_READ |=> !out_valid && !busy)
    else $error("load item produced a result or raised busy");

  // a computed result comes out as busy drops
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(busy) |-> !busy && !out_out_of_range)
    else $error("computed result while still busy or flagged");

endmodule

bind attention_matmul_engine_unit ame_checker u_ame_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_product      (out_product),
  .out_out_of_range (out_out_of_range)
);
